/* sv/quad_cull_and_winding_defines.svh */
// Assertion macros for the quad cull and winding block.
`ifndef QUAD_CULL_AND_WINDING_DEFINES_SVH
`define QUAD_CULL_AND_WINDING_DEFINES_SVH

`ifndef SYNTHESIS

`define QCW_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

`define QCW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define QCW_ASSERT_IMPLY(label, ante, cons)

`define QCW_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* sv/qcw_pkg.sv */
// Types and constants shared by the quad cull and winding block.
package qcw_pkg;

  typedef logic signed [15:0] coord_t;
  typedef logic signed [17:0] depth_t;
  typedef logic        [11:0] extent_t;
  typedef logic        [16:0] mean_t;

  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  localparam logic [2:0] REG_VIEWPORT_WIDTH  = 3'd0;
  localparam logic [2:0] REG_VIEWPORT_HEIGHT = 3'd1;
  localparam logic [2:0] REG_DOUBLE_SIDED    = 3'd2;
  localparam logic [2:0] REG_FRONT_CW        = 3'd3;
  localparam logic [2:0] REG_Y_AXIS_UP       = 3'd4;

  localparam extent_t WIDTH_RESET  = 12'd640;
  localparam extent_t HEIGHT_RESET = 12'd480;

  localparam logic [16:0] DEPTH_ONE = 17'd65536;

endpackage

/* sv/qcw_ifs.sv */
// Handshake channel interfaces for quads in and cull results out.
interface qcw_quad_if;
  import qcw_pkg::*;

  logic   valid;
  logic   ready;
  coord_t vx0;
  coord_t vy0;
  depth_t vz0;
  coord_t vx1;
  coord_t vy1;
  depth_t vz1;
  coord_t vx2;
  coord_t vy2;
  depth_t vz2;
  coord_t vx3;
  coord_t vy3;
  depth_t vz3;

  modport source (
    output valid, vx0, vy0, vz0, vx1, vy1, vz1, vx2, vy2, vz2, vx3, vy3, vz3,
    input  ready
  );
  modport sink (
    input  valid, vx0, vy0, vz0, vx1, vy1, vz1, vx2, vy2, vz2, vx3, vy3, vz3,
    output ready
  );
endinterface

interface qcw_res_if;
  import qcw_pkg::*;

  logic  valid;
  logic  ready;
  logic  visible;
  logic  is_clockwise;
  mean_t mean_depth;

  modport source (output valid, visible, is_clockwise, mean_depth, input ready);
  modport sink (input valid, visible, is_clockwise, mean_depth, output ready);
endinterface

/* sv/quad_cull_and_winding.sv */
// Quad depth, screen and facing cull with winding and mean depth output.
//
// One request on in_quad carries four projected vertices (x, y in Q12.4
// pixels, z in Q1.16). Each request produces exactly one result on out_res:
// the visible flag, the projected winding and the mean depth of a visible quad.
// The work runs in a three-stage pipeline: vertex checks and diagonal
// differences, two 17x17 diagonal products, then the area sign and the cull
// decision into the result register. One request is accepted every cycle
// while out_res is not stalled.
// When out_res is stalled the whole pipeline holds and in_quad.ready drops;
// it rises again in the cycle the held result is taken.
// The APB port writes and reads the viewport size, double_sided,
// front_clockwise and y_axis_up; the user must write it only while the pipeline
// is empty, as the block does not enforce it. Synchronous reset empties the
// pipeline and restores 640x480 single-sided, counterclockwise-front, y-down culling.
`include "quad_cull_and_winding_defines.svh"

module quad_cull_and_winding (
  input  logic                          clk,
  input  logic                          rst_n,
  qcw_quad_if.sink                      in_quad,
  qcw_res_if.source                     out_res,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [qcw_pkg::CFG_AW-1:0]    cfg_paddr,
  input  logic [qcw_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic [qcw_pkg::CFG_DW-1:0]    cfg_prdata,
  output logic                          cfg_pready
);
  import qcw_pkg::*;

  extent_t width_r;
  extent_t height_r;
  logic    double_sided_r;
  logic    front_cw_r;
  logic    y_up_r;

  logic       cfg_wr;
  logic [2:0] cfg_idx;

  logic               adv;
  logic               s1_valid_r;
  logic signed [16:0] dxa_r, dya_r, dxb_r, dyb_r;
  logic signed [16:0] dxa_nxt, dya_nxt, dxb_nxt, dyb_nxt;
  logic               s1_pass_r, s1_pass_nxt;
  mean_t              s1_mean_r, s1_mean_nxt;

  logic               s2_valid_r;
  logic signed [33:0] pa_r, pb_r;
  logic               s2_pass_r;
  mean_t              s2_mean_r;

  logic               out_valid_r;
  logic               visible_r, visible_nxt;
  logic               cw_r, cw_nxt;
  mean_t              mean_r, mean_nxt;

  coord_t             vx [4];
  coord_t             vy [4];
  depth_t             vz [4];
  logic               depth_ok;
  logic               on_screen;
  logic signed [19:0] zsum;
  logic signed [34:0] area;
  logic               area_pos;
  logic               cw_calc;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r        <= WIDTH_RESET;
      height_r       <= HEIGHT_RESET;
      double_sided_r <= 1'b0;
      front_cw_r     <= 1'b0;
      y_up_r         <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_VIEWPORT_WIDTH:  width_r        <= cfg_pwdata[11:0];
        REG_VIEWPORT_HEIGHT: height_r       <= cfg_pwdata[11:0];
        REG_DOUBLE_SIDED:    double_sided_r <= cfg_pwdata[0];
        REG_FRONT_CW:        front_cw_r     <= cfg_pwdata[0];
        REG_Y_AXIS_UP:       y_up_r         <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_VIEWPORT_WIDTH:  cfg_prdata = {20'd0, width_r};
      REG_VIEWPORT_HEIGHT: cfg_prdata = {20'd0, height_r};
      REG_DOUBLE_SIDED:    cfg_prdata = {31'd0, double_sided_r};
      REG_FRONT_CW:        cfg_prdata = {31'd0, front_cw_r};
      REG_Y_AXIS_UP:       cfg_prdata = {31'd0, y_up_r};
      default:             cfg_prdata = '0;
    endcase
  end

  assign adv           = !out_valid_r || out_res.ready;
  assign in_quad.ready = adv;

  // The shoelace sum of a quad equals the cross product of its diagonals;
  // the y axis direction picks the clockwise sign: positive if y_up, else negative.
  always_comb begin
    vx[0] = in_quad.vx0; vy[0] = in_quad.vy0; vz[0] = in_quad.vz0;
    vx[1] = in_quad.vx1; vy[1] = in_quad.vy1; vz[1] = in_quad.vz1;
    vx[2] = in_quad.vx2; vy[2] = in_quad.vy2; vz[2] = in_quad.vz2;
    vx[3] = in_quad.vx3; vy[3] = in_quad.vy3; vz[3] = in_quad.vz3;
    depth_ok  = 1'b1;
    on_screen = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (vz[i][17] || (vz[i][16:0] > DEPTH_ONE)) begin
        depth_ok = 1'b0;
      end
      if (!vx[i][15] && !vy[i][15] &&
          (vx[i] <= {width_r, 4'h0}) && (vy[i] <= {height_r, 4'h0})) begin
        on_screen = 1'b1;
      end
    end
    zsum = 20'(vz[0]) + 20'(vz[1]) + 20'(vz[2]) + 20'(vz[3]);
    s1_mean_nxt = zsum[18:2];
    s1_pass_nxt = depth_ok && on_screen;
    dxa_nxt = {vx[2][15], vx[2]} - {vx[0][15], vx[0]};
    dya_nxt = {vy[3][15], vy[3]} - {vy[1][15], vy[1]};
    dxb_nxt = {vx[3][15], vx[3]} - {vx[1][15], vx[1]};
    dyb_nxt = {vy[2][15], vy[2]} - {vy[0][15], vy[0]};
  end

  always_comb begin
    area        = {pa_r[33], pa_r} - {pb_r[33], pb_r};
    area_pos    = !area[34] && (area != '0);
    cw_calc     = y_up_r ? area_pos : area[34];
    visible_nxt = s2_pass_r && (double_sided_r || (cw_calc == front_cw_r));
    cw_nxt      = s2_pass_r && cw_calc;
    mean_nxt    = visible_nxt ? s2_mean_r : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= in_quad.valid;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dxa_r     <= dxa_nxt;
      dya_r     <= dya_nxt;
      dxb_r     <= dxb_nxt;
      dyb_r     <= dyb_nxt;
      s1_pass_r <= s1_pass_nxt;
      s1_mean_r <= s1_mean_nxt;
      pa_r      <= dxa_r * dya_r;
      pb_r      <= dxb_r * dyb_r;
      s2_pass_r <= s1_pass_r;
      s2_mean_r <= s1_mean_r;
      visible_r <= visible_nxt;
      cw_r      <= cw_nxt;
      mean_r    <= mean_nxt;
    end
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.visible      = visible_r;
  assign out_res.is_clockwise = cw_r;
  assign out_res.mean_depth   = mean_r;

  `QCW_ASSERT_IMPLY(a_stall_blocks_input, out_valid_r && !out_res.ready, !in_quad.ready)
  `QCW_ASSERT_NEXT(a_accept_enters_pipe, in_quad.valid && in_quad.ready, s1_valid_r)
  `QCW_ASSERT_IMPLY(a_visible_faces_front,
                    out_valid_r && visible_r && !double_sided_r, cw_r == front_cw_r)
  `QCW_ASSERT_IMPLY(a_culled_zero_depth, out_valid_r && !visible_r, mean_r == '0)
  `QCW_ASSERT_IMPLY(a_mean_in_range, out_valid_r && visible_r, mean_r <= DEPTH_ONE)

endmodule
